[rtl/core/dns_name_decompressor_assert.svh]
// assertion helpers for the name decompressor
`ifndef DNS_NAME_DECOMPRESSOR_ASSERT_SVH
`define DNS_NAME_DECOMPRESSOR_ASSERT_SVH

// same-cycle implication
`define DND_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("dns name decompressor: check failed");

// next-cycle implication
`define DND_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("dns name decompressor: check failed");

`endif

[rtl/core/dnd_pkg.sv]
package dnd_pkg;

    localparam int PACKET_BYTES = 512;
    localparam int NAME_BYTES   = 256;
    localparam int PKT_AW       = $clog2(PACKET_BYTES);
    localparam int NAME_AW      = $clog2(NAME_BYTES);
    localparam int NEXT_W       = NAME_AW + 2;
    localparam int CHUNK_BYTES  = 8;
    localparam int FILL_W       = 4;
    localparam int JUMP_W       = 8;
    localparam int USED_W       = 9;
    localparam int PTR_W        = 14;

    localparam logic [7:0]        PTR_MARK        = 8'd192;
    localparam logic [7:0]        DOT_CHAR        = 8'h2E;
    localparam logic [JUMP_W-1:0] MAX_JUMPS_RESET = 8'd16;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_LONG  = 2'd1,
        ERR_JUMPS = 2'd2,
        ERR_RANGE = 2'd3
    } t_err;

    typedef struct packed {
        logic       opcode;
        logic [8:0] byte_address;
        logic [7:0] byte_value;
        logic [8:0] name_start;
    } t_in_item;

    typedef struct packed {
        logic [63:0] name_chunk;
        logic [3:0]  chunk_bytes;
        logic        last;
        logic [8:0]  consumed;
        logic [1:0]  error_code;
    } t_out_item;

endpackage

[rtl/core/dnd_in_if.sv]
interface dnd_in_if;
    import dnd_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/dnd_out_if.sv]
interface dnd_out_if;
    import dnd_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/dnd_ram.sv]
module dnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/dns_name_decompressor.sv]
// DNS name decompressor. A write beat (opcode 0) stores one packet byte in a 512-byte store.
// A decode beat (opcode 1) walks the encoded name from name_start one store byte per cycle
// between pointer jumps, following compression pointers, and is then given out as dotted text
// in beats of up to eight characters, the final beat flagged by last and carrying consumed.
// The walk and the output beats, which also wait on output stalls, are paced by the single
// read port of the packet store and of the name buffer. No input is taken until the last
// beat has gone. max_jumps (reset 16) is written through i_cfg_we / i_cfg_wdata; the user
// must do so only while the block is idle, which the block itself does not enforce.
// An error (name over 255 raw bytes, too many jumps, walk or pointer outside the store)
// gives a single empty last beat with the error code.
`include "dns_name_decompressor_assert.svh"

module dns_name_decompressor (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [dnd_pkg::JUMP_W-1:0] i_cfg_wdata,
    dnd_in_if.sink                     i_in,
    dnd_out_if.source                  o_out
);
    import dnd_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_EXAM  = 6'b000100,
        S_PTR   = 6'b001000,
        S_LOAD  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [JUMP_W-1:0]   r_max_jumps;
    logic [PKT_AW-1:0]   r_pos, n_pos;
    logic [PKT_AW-1:0]   r_start, n_start;
    logic [JUMP_W:0]     r_jumps, n_jumps;
    logic                r_jumped, n_jumped;
    logic [NAME_AW-1:0]  r_len, n_len;
    logic [NEXT_W-1:0]   r_next_b, n_next_b;
    logic [5:0]          r_ptr_hi, n_ptr_hi;
    logic [USED_W-1:0]   r_used, n_used;
    logic [NAME_AW-1:0]  r_tlen, n_tlen;
    logic [NAME_AW-1:0]  r_rd, n_rd;
    logic                r_dv, n_dv;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [63:0]         r_chunk, n_chunk;
    logic                r_last, n_last;
    t_err                r_err, n_err;

    logic                in_acc;
    logic                out_acc;
    logic                pkt_we;
    logic [PKT_AW-1:0]   pkt_raddr;
    logic [7:0]          pkt_q;
    logic                name_we;
    logic [NAME_AW-1:0]  name_waddr;
    logic [7:0]          name_wdata;
    logic [7:0]          name_q;
    logic [PKT_AW:0]     pos_inc;
    logic                pos_last;
    logic                boundary;
    logic [PTR_W-1:0]    target;
    logic [FILL_W-1:0]   cap_fill;
    logic                issue;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign pkt_we  = in_acc && (i_in.data.opcode == OP_WRITE)
                     && ({1'b0, i_in.data.byte_address} < 10'(PACKET_BYTES));

    assign pos_inc   = {1'b0, r_pos} + (PKT_AW+1)'(1);
    assign pos_last  = pos_inc >= (PKT_AW+1)'(PACKET_BYTES);
    assign pkt_raddr = (r_state == S_EXAM) ? pos_inc[PKT_AW-1:0] : r_pos;
    assign boundary  = (NEXT_W'(r_len) == r_next_b);
    assign target    = {r_ptr_hi, pkt_q};
    assign cap_fill  = r_fill + FILL_W'(r_dv);
    assign issue     = (r_state == S_LOAD) && (r_rd < r_tlen)
                       && (cap_fill < FILL_W'(CHUNK_BYTES));

    assign name_we    = (r_state == S_EXAM) && (pkt_q != 8'd0) && (pkt_q < PTR_MARK)
                        && (r_len < NAME_AW'(NAME_BYTES - 1)) && (r_len != '0);
    assign name_waddr = r_len - NAME_AW'(1);
    assign name_wdata = boundary ? DOT_CHAR : pkt_q;

    dnd_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_pkt_ram (
        .i_clk   (i_clk),
        .i_we    (pkt_we),
        .i_waddr (PKT_AW'(i_in.data.byte_address)),
        .i_wdata (i_in.data.byte_value),
        .i_raddr (pkt_raddr),
        .o_rdata (pkt_q)
    );

    dnd_ram #(
        .WIDTH (8),
        .DEPTH (NAME_BYTES)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (name_we),
        .i_waddr (name_waddr),
        .i_wdata (name_wdata),
        .i_raddr (r_rd),
        .o_rdata (name_q)
    );

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_start  = r_start;
        n_jumps  = r_jumps;
        n_jumped = r_jumped;
        n_len    = r_len;
        n_next_b = r_next_b;
        n_ptr_hi = r_ptr_hi;
        n_used   = r_used;
        n_tlen   = r_tlen;
        n_rd     = r_rd;
        n_dv     = r_dv;
        n_fill   = r_fill;
        n_chunk  = r_chunk;
        n_last   = r_last;
        n_err    = r_err;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.data.opcode == OP_DECODE)) begin
                    n_start  = PKT_AW'(i_in.data.name_start);
                    n_pos    = PKT_AW'(i_in.data.name_start);
                    n_jumps  = '0;
                    n_jumped = 1'b0;
                    n_len    = '0;
                    n_next_b = '0;
                    n_used   = '0;
                    n_chunk  = '0;
                    n_fill   = '0;
                    n_err    = ERR_NONE;
                    if ({1'b0, i_in.data.name_start} >= 10'(PACKET_BYTES)) begin
                        n_err   = ERR_RANGE;
                        n_last  = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_EXAM;
            end
            S_EXAM: begin
                if (pkt_q == 8'd0) begin
                    if (!r_jumped) begin
                        n_used = USED_W'(r_pos - r_start) + USED_W'(1);
                    end
                    n_tlen  = (r_len == '0) ? '0 : r_len - NAME_AW'(1);
                    n_rd    = '0;
                    n_dv    = 1'b0;
                    n_fill  = '0;
                    n_chunk = '0;
                    if (r_len <= NAME_AW'(1)) begin
                        n_last  = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_LOAD;
                    end
                end else if (pkt_q >= PTR_MARK) begin
                    if (pos_last) begin
                        n_err   = ERR_RANGE;
                        n_last  = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_ptr_hi = pkt_q[5:0];
                        n_state  = S_PTR;
                    end
                end else begin
                    if (r_len >= NAME_AW'(NAME_BYTES - 1)) begin
                        n_err   = ERR_LONG;
                        n_last  = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        if (boundary) begin
                            n_next_b = NEXT_W'(r_len) + NEXT_W'(pkt_q) + NEXT_W'(1);
                        end
                        n_len = r_len + NAME_AW'(1);
                        if (pos_last) begin
                            n_err   = ERR_RANGE;
                            n_last  = 1'b1;
                            n_state = S_OUT;
                        end else begin
                            n_pos = pos_inc[PKT_AW-1:0];
                        end
                    end
                end
            end
            S_PTR: begin
                n_jumps = r_jumps + (JUMP_W+1)'(1);
                if (target >= PTR_W'(PACKET_BYTES)) begin
                    n_err   = ERR_RANGE;
                    n_last  = 1'b1;
                    n_state = S_OUT;
                end else if (n_jumps > {1'b0, r_max_jumps}) begin
                    n_err   = ERR_JUMPS;
                    n_last  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    if (!r_jumped) begin
                        n_used   = USED_W'(r_pos - r_start) + USED_W'(2);
                        n_jumped = 1'b1;
                    end
                    n_pos   = PKT_AW'(target);
                    n_state = S_FETCH;
                end
            end
            S_LOAD: begin
                for (int i = 0; i < CHUNK_BYTES; i++) begin
                    if (r_dv && (r_fill == FILL_W'(i))) begin
                        n_chunk[8*i +: 8] = name_q;
                    end
                end
                n_fill = cap_fill;
                n_rd   = r_rd + NAME_AW'(issue);
                n_dv   = issue;
                if ((cap_fill == FILL_W'(CHUNK_BYTES)) || ((n_rd == r_tlen) && !issue)) begin
                    n_last  = (n_rd == r_tlen);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_acc) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_chunk = '0;
                        n_fill  = '0;
                        n_dv    = 1'b0;
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_jumps <= MAX_JUMPS_RESET;
            r_dv        <= 1'b0;
            r_last      <= 1'b0;
            r_jumps     <= '0;
            r_jumped    <= 1'b0;
            r_pos       <= '0;
        end else begin
            r_state  <= n_state;
            r_dv     <= n_dv;
            r_last   <= n_last;
            r_jumps  <= n_jumps;
            r_jumped <= n_jumped;
            r_pos    <= n_pos;
            if (i_cfg_we) begin
                r_max_jumps <= i_cfg_wdata;
            end
        end
    end

    // walk and beat payload
    always_ff @(posedge i_clk) begin
        r_start  <= n_start;
        r_len    <= n_len;
        r_next_b <= n_next_b;
        r_ptr_hi <= n_ptr_hi;
        r_used   <= n_used;
        r_tlen   <= n_tlen;
        r_rd     <= n_rd;
        r_fill   <= n_fill;
        r_chunk  <= n_chunk;
        r_err    <= n_err;
    end

    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid            = (r_state == S_OUT);
    assign o_out.data.name_chunk  = (r_err == ERR_NONE) ? r_chunk : '0;
    assign o_out.data.chunk_bytes = (r_err == ERR_NONE) ? r_fill : '0;
    assign o_out.data.last        = r_last;
    assign o_out.data.consumed    = (r_last && (r_err == ERR_NONE)) ? r_used : '0;
    assign o_out.data.error_code  = r_err;

    `DND_ASSERT_SAME(a_busy_when_out, o_out.valid, !i_in.ready)
    `DND_ASSERT_SAME(a_err_beat_empty, o_out.valid && (o_out.data.error_code != ERR_NONE), o_out.data.last && (o_out.data.chunk_bytes == '0))
    `DND_ASSERT_SAME(a_mid_beat_full, o_out.valid && !o_out.data.last, (o_out.data.chunk_bytes == FILL_W'(CHUNK_BYTES)) && (o_out.data.consumed == '0))
    `DND_ASSERT_NEXT(a_last_frees_input, out_acc && o_out.data.last, i_in.ready)
    `DND_ASSERT_SAME(a_read_only_in_load, r_dv, r_state == S_LOAD)

endmodule
